// ===== rtl/mesh3d_xyz_router_assert.svh =====
`ifndef MESH3D_XYZ_ROUTER_ASSERT_SVH
`define MESH3D_XYZ_ROUTER_ASSERT_SVH
// Assertion helpers used by the router top-level file.
`define MXR_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define MXR_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/mxr_pkg.sv =====
package mxr_pkg;
  localparam int Ports = 7;
  localparam int FifoDepth = 4;
  localparam int DimX = 4;
  localparam int DimY = 4;
  localparam int DimZ = 4;
  localparam int FlitWidth = 32;
  localparam int PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int CntW = $clog2(FifoDepth + 1);
  localparam int InW = 2 * Ports + Ports * FlitWidth;
  localparam int InBytesW = ((InW + 7) / 8) * 8;
  // Mesh dimensions are powers of two, so coordinates are bit fields of the node number.
  localparam int XBits = $clog2(DimX);
  localparam int YBits = $clog2(DimY);

  typedef enum logic [2:0] {
    P_NORTH = 3'd0, P_SOUTH = 3'd1, P_EAST = 3'd2, P_WEST = 3'd3,
    P_UP = 3'd4, P_DOWN = 3'd5, P_LOCAL = 3'd6
  } port_t;

  typedef enum logic [1:0] {
    TX_IDLE = 2'd0, TX_WAIT_HI = 2'd1, TX_WAIT_LO = 2'd2
  } tx_phase_t;

  typedef logic [FlitWidth-1:0] flit_t;

  typedef struct packed {
    logic [Ports-1:0] req;
    logic [Ports-1:0] ack;
    flit_t [Ports-1:0] flit;
  } tick_t;

  // XYZ dimension-order route; node numbers split as x + DimX*y + DimX*DimY*z.
  function automatic port_t route_of(logic [5:0] dst, logic [5:0] me);
    logic [5:0] dx, cx, dy, cy, dz, cz;
    dx = dst & 6'(DimX - 1);
    cx = me & 6'(DimX - 1);
    dy = (dst >> XBits) & 6'(DimY - 1);
    cy = (me >> XBits) & 6'(DimY - 1);
    dz = dst >> (XBits + YBits);
    cz = me >> (XBits + YBits);
    if (dst == me) return P_LOCAL;
    if (dx > cx) return P_EAST;
    if (dx < cx) return P_WEST;
    if (dy > cy) return P_NORTH;
    if (dy < cy) return P_SOUTH;
    if (dz > cz) return P_UP;
    if (dz < cz) return P_DOWN;
    return P_LOCAL;
  endfunction
endpackage

// ===== rtl/mesh3d_xyz_router.sv =====
// Seven-port XYZ router for a 3D mesh. Each input transaction is one router
// tick carrying every port's request, downstream acknowledge and flit; the
// result transaction carries the handshake outputs and flits after that tick.
// One tick is taken per cycle; its result is registered for the cycle after. A new tick is
// accepted when the output register is empty or its result is taken in the
// same cycle, so a stalled result stalls the input. Fields of
// in_tdata from bit 0: req_in, ack_in, flit_in north..local. out_tdata from
// bit 0: ack_out, req_out, flit_out north..local.
`include "mesh3d_xyz_router_assert.svh"
module mesh3d_xyz_router import mxr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // req_in[6:0], ack_in[13:7], flit_in_north..local 32 bits each, zero pad
  input  logic [InBytesW-1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // ack_out[6:0], req_out[13:7], flit_out_north..local 32 bits each, zero pad
  output logic [InBytesW-1:0] out_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  logic [5:0] node_id_r;
  logic out_valid_r;
  logic step;
  tick_t tick;
  logic [Ports-1:0] acko, reqo;
  flit_t [Ports-1:0] fo;

  assign in_tready = !out_valid_r || out_tready;
  assign step = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  always_comb begin
    tick.req = in_tdata[Ports-1:0];
    tick.ack = in_tdata[2*Ports-1:Ports];
    for (int p = 0; p < Ports; p++) tick.flit[p] = in_tdata[2*Ports + p*FlitWidth +: FlitWidth];
  end

  mxr_core u_core (
    .clk(clk), .rst_n(rst_n), .step(step), .tick(tick), .node_id(node_id_r),
    .ack_out(acko), .req_out(reqo), .flit_out(fo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) node_id_r <= cfg_data;
      if (step) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  always_comb begin
    out_tdata = '0;
    out_tdata[Ports-1:0] = acko;
    out_tdata[2*Ports-1:Ports] = reqo;
    for (int p = 0; p < Ports; p++) out_tdata[2*Ports + p*FlitWidth +: FlitWidth] = fo[p];
  end

  `MXR_ASSERT_NEXT(a_step_valid, step, out_tvalid)
  `MXR_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `MXR_ASSERT_IMPL(a_ready, !out_tvalid, in_tready)
endmodule

// ===== rtl/mxr_core.sv =====
// One router tick: receive, then transmit, updating all state in place.
module mxr_core import mxr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  tick_t            tick,
  input  logic [5:0]       node_id,
  output logic [Ports-1:0] ack_out,
  output logic [Ports-1:0] req_out,
  output flit_t [Ports-1:0] flit_out
);
  logic [Ports-1:0] rx_r, rx_nxt;
  tx_phase_t [Ports-1:0] tx_r, tx_nxt;
  flit_t store_r [Ports][FifoDepth];
  logic [PtrW-1:0] head_r [Ports];
  logic [PtrW-1:0] head_nxt [Ports];
  logic [CntW-1:0] cnt_r [Ports];
  logic [CntW-1:0] cnt_nxt [Ports];
  logic [Ports-1:0] resv_r, resv_nxt;
  port_t [Ports-1:0] gnt_r, gnt_nxt;
  logic [Ports-1:0] reqo_r, reqo_nxt, acko_r, acko_nxt;
  flit_t [Ports-1:0] fo_r, fo_nxt;
  logic [Ports-1:0] push;
  flit_t [Ports-1:0] pflit;
  logic [PtrW-1:0] waddr [Ports];

  always_comb begin
    logic [5:0] hops;
    logic [CntW-1:0] c;
    port_t o, t;
    flit_t f;
    logic ak;
    hops = '0; c = '0; o = P_NORTH; t = P_LOCAL; f = '0; ak = 1'b0;
    rx_nxt = rx_r; tx_nxt = tx_r; resv_nxt = resv_r; gnt_nxt = gnt_r;
    reqo_nxt = reqo_r; acko_nxt = acko_r; fo_nxt = fo_r;
    push = '0;
    for (int p = 0; p < Ports; p++) begin
      head_nxt[p] = head_r[p];
      cnt_nxt[p] = cnt_r[p];
      pflit[p] = tick.flit[p];
      // The depth is a power of two, so the slot index wraps by truncation.
      waddr[p] = PtrW'((CntW + 1)'(head_r[p]) + (CntW + 1)'(cnt_r[p]));
      if (p != int'(P_LOCAL)) begin
        hops = tick.flit[p][11:6];
        if (hops != 6'd63) hops = hops + 6'd1;
        pflit[p][11:6] = hops;
      end
      if (!rx_r[p]) begin
        if (tick.req[p] && cnt_r[p] < CntW'(FifoDepth)) begin
          push[p] = 1'b1;
          cnt_nxt[p] = cnt_r[p] + 1'b1;
          acko_nxt[p] = 1'b1;
          rx_nxt[p] = 1'b1;
        end
      end else if (!tick.req[p]) begin
        acko_nxt[p] = 1'b0;
        rx_nxt[p] = 1'b0;
      end
    end
    for (int p = 0; p < Ports; p++) begin
      o = gnt_r[p];
      ak = tick.ack[o];
      c = cnt_nxt[p];
      case (tx_r[p])
        TX_WAIT_HI: begin
          if (ak) begin
            reqo_nxt[o] = 1'b0;
            tx_nxt[p] = TX_WAIT_LO;
          end
        end
        TX_WAIT_LO: begin
          if (!ak) begin
            head_nxt[p] = (head_r[p] == PtrW'(FifoDepth - 1)) ? '0 : head_r[p] + 1'b1;
            cnt_nxt[p] = c - 1'b1;
            resv_nxt[o] = 1'b0;
            tx_nxt[p] = TX_IDLE;
          end
        end
        default: begin
          if (c != '0) begin
            // A freshly pushed flit into an empty FIFO is the head this tick.
            f = (cnt_r[p] == '0) ? pflit[p] : store_r[p][head_r[p]];
            t = route_of(f[5:0], node_id);
            if (!resv_nxt[t]) begin
              resv_nxt[t] = 1'b1;
              gnt_nxt[p] = t;
              fo_nxt[t] = f;
              reqo_nxt[t] = 1'b1;
              tx_nxt[p] = TX_WAIT_HI;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r <= '0; resv_r <= '0; reqo_r <= '0; acko_r <= '0; fo_r <= '0;
      for (int p = 0; p < Ports; p++) begin
        tx_r[p] <= TX_IDLE; gnt_r[p] <= P_NORTH;
        head_r[p] <= '0; cnt_r[p] <= '0;
      end
    end else if (step) begin
      rx_r <= rx_nxt; tx_r <= tx_nxt; resv_r <= resv_nxt; gnt_r <= gnt_nxt;
      reqo_r <= reqo_nxt; acko_r <= acko_nxt; fo_r <= fo_nxt;
      for (int p = 0; p < Ports; p++) begin
        head_r[p] <= head_nxt[p]; cnt_r[p] <= cnt_nxt[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < Ports; p++) begin
      if (step && push[p]) store_r[p][waddr[p]] <= pflit[p];
    end
  end

  assign ack_out = acko_r;
  assign req_out = reqo_r;
  assign flit_out = fo_r;
endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import mxr_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InBytesW-1:0] in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  logic [InBytesW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [5:0]          cfg_data;

  mesh3d_xyz_router i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Router state mirrored for prediction.
  logic [5:0]      my_node;
  logic            rx_busy [Ports];
  tx_phase_t       tx_state [Ports];
  flit_t           fifo_mem [Ports][FifoDepth];
  int              fifo_rd [Ports];
  int              fifo_fill [Ports];
  logic            out_taken [Ports];
  int              grant [Ports];
  logic [Ports-1:0] req_hold;
  logic [Ports-1:0] ack_hold;
  flit_t           flit_hold [Ports];

  logic [InBytesW-1:0] tick_q[$];
  logic [InBytesW-1:0] expected_q[$];
  int  errors;
  int  out_seen;
  int  in_gap;
  int  out_gap;
  int  hold_left;
  bit  hold_done;
  bit  calm;
  int  idle_cycles;

  // Stimulus generator state: request and acknowledge levels with hold counts.
  logic rq_lvl [Ports];
  int   rq_left [Ports];
  logic ak_lvl [Ports];
  int   ak_left [Ports];

  function automatic port_t xyz_route(logic [5:0] dst);
    int dx, cx, dy, cy, dz, cz;
    dx = dst % DimX;
    cx = my_node % DimX;
    dy = (dst / DimX) % DimY;
    cy = (my_node / DimX) % DimY;
    dz = dst / (DimX * DimY);
    cz = my_node / (DimX * DimY);
    if (dst == my_node) return P_LOCAL;
    if (dx > cx) return P_EAST;
    if (dx < cx) return P_WEST;
    if (dy > cy) return P_NORTH;
    if (dy < cy) return P_SOUTH;
    if (dz > cz) return P_UP;
    if (dz < cz) return P_DOWN;
    return P_LOCAL;
  endfunction

  function automatic logic [InBytesW-1:0] router_tick(logic [InBytesW-1:0] t);
    logic [Ports-1:0] rq;
    logic [Ports-1:0] ak;
    flit_t f;
    port_t dst;
    int o;
    logic [InBytesW-1:0] r;
    rq = t[6:0];
    ak = t[13:7];
    for (int p = 0; p < Ports; p++) begin
      if (!rx_busy[p]) begin
        if (rq[p] && fifo_fill[p] < FifoDepth) begin
          f = t[14 + 32 * p +: 32];
          // Hop count saturates at its maximum; local injections keep theirs.
          if (p != P_LOCAL && f[11:6] != 6'h3f) f[11:6] = f[11:6] + 6'd1;
          fifo_mem[p][(fifo_rd[p] + fifo_fill[p]) % FifoDepth] = f;
          fifo_fill[p]++;
          ack_hold[p] = 1'b1;
          rx_busy[p] = 1'b1;
        end
      end else if (!rq[p]) begin
        ack_hold[p] = 1'b0;
        rx_busy[p] = 1'b0;
      end
    end
    for (int p = 0; p < Ports; p++) begin
      o = grant[p];
      if (tx_state[p] == TX_WAIT_HI) begin
        if (ak[o]) begin
          req_hold[o] = 1'b0;
          tx_state[p] = TX_WAIT_LO;
        end
      end else if (tx_state[p] == TX_WAIT_LO) begin
        if (!ak[o]) begin
          fifo_rd[p] = (fifo_rd[p] + 1) % FifoDepth;
          fifo_fill[p]--;
          out_taken[o] = 1'b0;
          tx_state[p] = TX_IDLE;
        end
      end else if (fifo_fill[p] != 0) begin
        f = fifo_mem[p][fifo_rd[p]];
        dst = xyz_route(f[5:0]);
        if (!out_taken[dst]) begin
          out_taken[dst] = 1'b1;
          grant[p] = int'(dst);
          flit_hold[dst] = f;
          req_hold[dst] = 1'b1;
          tx_state[p] = TX_WAIT_HI;
        end
      end
    end
    r = '0;
    r[6:0] = ack_hold;
    r[13:7] = req_hold;
    for (int p = 0; p < Ports; p++) r[14 + 32 * p +: 32] = flit_hold[p];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic flit_t make_flit();
    flit_t f;
    int r;
    f = $urandom;
    r = $urandom_range(0, 7);
    if (r < 2) f[5:0] = my_node;
    r = $urandom_range(0, 7);
    if (r == 0) f[11:6] = 6'h3f;
    else if (r == 1) f[11:6] = 6'h3e;
    return f;
  endfunction

  function automatic logic [InBytesW-1:0] pack_tick(logic [Ports-1:0] rq,
                                                    logic [Ports-1:0] ak,
                                                    flit_t f [Ports]);
    logic [InBytesW-1:0] t;
    t = '0;
    t[6:0] = rq;
    t[13:7] = ak;
    for (int p = 0; p < Ports; p++) t[14 + 32 * p +: 32] = f[p];
    return t;
  endfunction

  // Mostly well-formed four-phase traffic: levels held for random stretches,
  // with occasional single-tick glitches as noise.
  task automatic queue_random(int n);
    logic [Ports-1:0] rq;
    logic [Ports-1:0] ak;
    flit_t f [Ports];
    for (int i = 0; i < n; i++) begin
      for (int p = 0; p < Ports; p++) begin
        if (rq_left[p] == 0) begin
          rq_lvl[p] = ~rq_lvl[p];
          rq_left[p] = rq_lvl[p] ? $urandom_range(1, 6) : $urandom_range(1, 3);
        end
        rq_left[p]--;
        if (ak_left[p] == 0) begin
          ak_lvl[p] = ~ak_lvl[p];
          ak_left[p] = $urandom_range(1, 5);
        end
        ak_left[p]--;
        rq[p] = rq_lvl[p] ^ ($urandom_range(0, 19) == 0);
        ak[p] = ak_lvl[p] ^ ($urandom_range(0, 19) == 0);
        f[p] = make_flit();
      end
      tick_q.push_back(pack_tick(rq, ak, f));
    end
  endtask

  task automatic queue_directed();
    flit_t f [Ports];
    logic [5:0] dsts [Ports];
    for (int p = 0; p < Ports; p++) f[p] = '0;
    tick_q.push_back(pack_tick('0, '0, f));
    for (int p = 0; p < Ports; p++) f[p] = '1;
    tick_q.push_back(pack_tick('1, '0, f));
    tick_q.push_back(pack_tick('1, '0, f));
    tick_q.push_back(pack_tick('0, '1, f));
    tick_q.push_back(pack_tick('0, '0, f));
    // With node 21 at (1,1,1), these reach every output direction.
    dsts = '{6'd25, 6'd17, 6'd22, 6'd20, 6'd37, 6'd5, 6'd21};
    for (int p = 0; p < Ports; p++) begin
      f[p] = {20'h5a5a5, 6'h3e, dsts[(p + 2) % Ports]};
    end
    for (int k = 0; k < 3; k++) begin
      tick_q.push_back(pack_tick('1, '0, f));
      tick_q.push_back(pack_tick('0, '0, f));
      tick_q.push_back(pack_tick('0, '1, f));
      tick_q.push_back(pack_tick('0, '0, f));
    end
    for (int k = 0; k < 6; k++) begin
      tick_q.push_back(pack_tick('1, 7'(k * 37), f));
      tick_q.push_back(pack_tick('0, '1, f));
    end
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || expected_q.size() != 0 || in_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_node(logic [5:0] id);
    cfg_data <= id;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    my_node = id;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input driver.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(router_tick(in_tdata));
        void'(tick_q.pop_front());
        in_gap = pick_gap();
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_tdata <= tick_q[0];
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stall control.
  always @(posedge clk) begin
    logic [InBytesW-1:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        out_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transaction %h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (want[13:0] != out_tdata[13:0]) begin
            errors++;
            if (errors <= 10)
              $display("ack/req mismatch: expected ack %b req %b, got ack %b req %b",
                       want[6:0], want[13:7], out_tdata[6:0], out_tdata[13:7]);
          end
          for (int p = 0; p < Ports; p++) begin
            if (want[14 + 32 * p +: 32] != out_tdata[14 + 32 * p +: 32]) begin
              errors++;
              if (errors <= 10)
                $display("flit_out port %0d mismatch: expected %h, got %h", p,
                         want[14 + 32 * p +: 32], out_tdata[14 + 32 * p +: 32]);
            end
          end
        end
        out_gap = pick_gap();
      end
      // One long hold-off lets the output register and input side back up.
      if (!hold_done && out_seen == 150) begin
        hold_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction anywhere.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready) || hold_left > 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("FAIL mesh3d_xyz_router");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    errors = 0;
    out_seen = 0;
    in_gap = 0;
    out_gap = 0;
    hold_left = 0;
    hold_done = 1'b0;
    calm = 1'b0;
    idle_cycles = 0;
    my_node = '0;
    req_hold = '0;
    ack_hold = '0;
    for (int p = 0; p < Ports; p++) begin
      rx_busy[p] = 1'b0;
      tx_state[p] = TX_IDLE;
      fifo_rd[p] = 0;
      fifo_fill[p] = 0;
      out_taken[p] = 1'b0;
      grant[p] = 0;
      flit_hold[p] = '0;
      rq_lvl[p] = 1'b0;
      rq_left[p] = 0;
      ak_lvl[p] = 1'b0;
      ak_left[p] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_node(6'd21);
    queue_directed();
    wait_drained();
    queue_random(160);
    wait_drained();
    write_node(6'd63);
    calm = 1'b1;
    queue_random(160);
    wait_drained();
    calm = 1'b0;
    write_node(6'd0);
    queue_random(160);
    wait_drained();
    write_node(6'($urandom_range(1, 62)));
    queue_random(160);
    wait_drained();
    if (errors == 0) begin
      $display("PASS mesh3d_xyz_router");
    end else begin
      $display("FAIL mesh3d_xyz_router");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mxr_pkg.sv
rtl/mxr_core.sv
rtl/mesh3d_xyz_router.sv
verif/tb_top.sv
